FILE: rtl/core/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion pipeline.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none
package rmq_pkg;

	localparam int RAD_W  = 64;
	localparam int ROOT_W = 32;
	localparam int NUM_W  = 62;
	localparam int LANES  = 4;

	localparam logic [0:0] CFG_SMALL_W = 1'b0;
	localparam logic [0:0] CFG_DIAG    = 1'b1;

	localparam logic [30:0]        SMALL_W_RESET = 31'd1073742;
	localparam logic signed [31:0] DIAG_RESET    = -32'sd1063004406;

	typedef struct packed {
		logic signed [31:0] col0_x;
		logic signed [31:0] col0_y;
		logic signed [31:0] col0_z;
		logic signed [31:0] col1_x;
		logic signed [31:0] col1_y;
		logic signed [31:0] col1_z;
		logic signed [31:0] col2_x;
		logic signed [31:0] col2_y;
		logic signed [31:0] col2_z;
	} in_t;

	typedef struct packed {
		logic signed [31:0] quat_w;
		logic signed [31:0] quat_x;
		logic signed [31:0] quat_y;
		logic signed [31:0] quat_z;
		logic               near_half_turn;
		logic               bad_matrix;
	} out_t;

	// skew differences and half-turn candidate vector, ahead of the first root
	typedef struct packed {
		logic signed [32:0] d0;
		logic signed [32:0] d1;
		logic signed [32:0] d2;
		logic signed [33:0] v1;
		logic signed [33:0] v2;
		logic signed [33:0] v3;
		logic               bad;
	} pre_t;

	// everything the divider setup needs, carried through the norm root
	typedef struct packed {
		logic                  half;
		logic                  bad;
		logic [30:0]           w;
		logic [2:0]            dneg;
		logic [2:0][32:0]      dmag;
		logic [2:0]            vneg;
		logic [LANES-1:0][30:0] ms;
	} norm_t;

	typedef struct packed {
		logic             half;
		logic             bad;
		logic             zero_n;
		logic [30:0]      w;
		logic [LANES-1:0] neg;
	} div_meta_t;

endpackage
`default_nettype wire

FILE: rtl/core/rmq_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on rmq_pkg for the radicand and root widths; carries a payload alongside.
`default_nettype none
module rmq_isqrt #(
	parameter int PW = 1
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	input  wire [rmq_pkg::RAD_W-1:0]      in_rad,
	input  wire [PW-1:0]                  in_pay,
	output logic                          out_valid,
	output logic [rmq_pkg::ROOT_W-1:0]    out_root,
	output logic [PW-1:0]                 out_pay
);
	localparam int NS    = rmq_pkg::RAD_W / 2;
	localparam int RW    = rmq_pkg::ROOT_W;
	localparam int REM_W = RW + 3;

	logic                          v_s    [1:NS];
	logic [rmq_pkg::RAD_W-1:0]     rad_s  [1:NS];
	logic [REM_W-1:0]              rem_s  [1:NS];
	logic [RW-1:0]                 root_s [1:NS];
	logic [PW-1:0]                 pay_s  [1:NS];

	genvar k;
	generate
		for (k = 0; k < NS; k++) begin : g_stage
			logic                      sv;
			logic [rmq_pkg::RAD_W-1:0] srad;
			logic [REM_W-1:0]          srem;
			logic [RW-1:0]             sroot;
			logic [PW-1:0]             spay;
			logic [REM_W-1:0]          cur;
			logic [REM_W-1:0]          trial;
			logic                      ge;

			if (k == 0) begin : g_src_in
				assign sv    = in_valid;
				assign srad  = in_rad;
				assign srem  = '0;
				assign sroot = '0;
				assign spay  = in_pay;
			end else begin : g_src_reg
				assign sv    = v_s[k];
				assign srad  = rad_s[k];
				assign srem  = rem_s[k];
				assign sroot = root_s[k];
				assign spay  = pay_s[k];
			end

			// bring down the next two radicand bits and try root*4+1
			assign cur   = {srem[REM_W-3:0], srad[rmq_pkg::RAD_W-1 -: 2]};
			assign trial = REM_W'({sroot, 2'b01});
			assign ge    = cur >= trial;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k+1] <= 1'b0;
				end else begin
					v_s[k+1] <= sv;
				end
			end

			always_ff @(posedge clk) begin
				rad_s[k+1]  <= {srad[rmq_pkg::RAD_W-3:0], 2'b00};
				rem_s[k+1]  <= ge ? cur - trial : cur;
				root_s[k+1] <= {sroot[RW-2:0], ge};
				pay_s[k+1]  <= spay;
			end
		end
	endgenerate

	assign out_valid = v_s[NS];
	assign out_root  = root_s[NS];
	assign out_pay   = pay_s[NS];
endmodule
`default_nettype wire

FILE: rtl/core/rmq_norm_sq.sv
// Branch decision, magnitudes and sum of squares ahead of the norm root.
// Depends on rmq_pkg for pre_t and norm_t; three register stages.
`default_nettype none
module rmq_norm_sq (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	input  wire [31:0]            in_w,
	input  rmq_pkg::pre_t         in_pre,
	input  wire [30:0]            small_w,
	output logic                  out_valid,
	output logic [63:0]           out_sum,
	output rmq_pkg::norm_t        out_meta
);
	logic                          valid_s2, valid_s3, valid_s4;
	rmq_pkg::norm_t                meta_s2, meta_s3, meta_s4;
	logic [rmq_pkg::LANES-1:0][61:0] sq_s3;
	logic [63:0]                   sum_s4;

	logic [rmq_pkg::LANES-1:0][33:0] mag;
	logic                          big;
	rmq_pkg::norm_t                meta_c;

	always_comb begin
		mag[0] = {2'b00, in_w};
		mag[1] = in_pre.v1[33] ? 34'(-in_pre.v1) : 34'(in_pre.v1);
		mag[2] = in_pre.v2[33] ? 34'(-in_pre.v2) : 34'(in_pre.v2);
		mag[3] = in_pre.v3[33] ? 34'(-in_pre.v3) : 34'(in_pre.v3);
		big = 1'b0;
		for (int i = 0; i < rmq_pkg::LANES; i++) begin
			if (mag[i][33:31] != 3'b000) big = 1'b1;
		end
		meta_c.half = in_w <= {1'b0, small_w};
		meta_c.bad  = in_pre.bad;
		meta_c.w    = in_w[30:0];
		meta_c.dneg = {in_pre.d2[32], in_pre.d1[32], in_pre.d0[32]};
		meta_c.dmag[0] = in_pre.d0[32] ? 33'(-in_pre.d0) : 33'(in_pre.d0);
		meta_c.dmag[1] = in_pre.d1[32] ? 33'(-in_pre.d1) : 33'(in_pre.d1);
		meta_c.dmag[2] = in_pre.d2[32] ? 33'(-in_pre.d2) : 33'(in_pre.d2);
		meta_c.vneg = {in_pre.v3[33], in_pre.v2[33], in_pre.v1[33]};
		for (int i = 0; i < rmq_pkg::LANES; i++) begin
			meta_c.ms[i] = big ? mag[i][31:1] : mag[i][30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		meta_s2 <= meta_c;
		meta_s3 <= meta_s2;
		meta_s4 <= meta_s3;
		for (int i = 0; i < rmq_pkg::LANES; i++) begin
			sq_s3[i] <= meta_s2.ms[i] * meta_s2.ms[i];
		end
		sum_s4 <= 64'(sq_s3[0]) + 64'(sq_s3[1]) + 64'(sq_s3[2]) + 64'(sq_s3[3]);
	end

	assign out_valid = valid_s4;
	assign out_sum   = sum_s4;
	assign out_meta  = meta_s4;
endmodule
`default_nettype wire

FILE: rtl/core/rmq_div.sv
// Four-lane pipelined restoring divider with a shared divisor, one quotient bit a stage.
// Depends on rmq_pkg for lane count, numerator width and div_meta_t.
`default_nettype none
module rmq_div (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      in_valid,
	input  wire [rmq_pkg::LANES-1:0][rmq_pkg::NUM_W-1:0] in_num,
	input  wire [31:0]                               in_den,
	input  rmq_pkg::div_meta_t                       in_meta,
	output logic                                     out_valid,
	output logic [rmq_pkg::LANES-1:0][30:0]          out_quo,
	output logic [rmq_pkg::LANES-1:0]                out_ovf,
	output rmq_pkg::div_meta_t                       out_meta
);
	localparam int NST = 31;
	localparam int L   = rmq_pkg::LANES;

	logic                   v_s    [0:NST];
	logic [L-1:0][31:0]     rem_s  [0:NST];
	logic [L-1:0][30:0]     low_s  [0:NST];
	logic [L-1:0][30:0]     quo_s  [0:NST];
	logic [L-1:0]           ovf_s  [0:NST];
	logic [31:0]            den_s  [0:NST];
	rmq_pkg::div_meta_t     meta_s [0:NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	// quotient of 2^31 or more saturates anyway; flag it and keep 31 bits
	always_ff @(posedge clk) begin
		for (int i = 0; i < L; i++) begin
			ovf_s[0][i] <= 32'(in_num[i][61:31]) >= in_den;
			rem_s[0][i] <= 32'(in_num[i][61:31]);
			low_s[0][i] <= in_num[i][30:0];
		end
		quo_s[0]  <= '0;
		den_s[0]  <= in_den;
		meta_s[0] <= in_meta;
	end

	genvar j;
	generate
		for (j = 0; j < NST; j++) begin : g_stage
			logic [L-1:0][32:0] cur;
			logic [L-1:0]       ge;

			always_comb begin
				for (int i = 0; i < L; i++) begin
					cur[i] = {rem_s[j][i], low_s[j][i][30]};
					ge[i]  = cur[i] >= {1'b0, den_s[j]};
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[j+1] <= 1'b0;
				end else begin
					v_s[j+1] <= v_s[j];
				end
			end

			always_ff @(posedge clk) begin
				for (int i = 0; i < L; i++) begin
					rem_s[j+1][i] <= ge[i] ? 32'(cur[i] - {1'b0, den_s[j]}) : cur[i][31:0];
					low_s[j+1][i] <= {low_s[j][i][29:0], 1'b0};
					quo_s[j+1][i] <= {quo_s[j][i][29:0], ge[i]};
				end
				ovf_s[j+1]  <= ovf_s[j];
				den_s[j+1]  <= den_s[j];
				meta_s[j+1] <= meta_s[j];
			end
		end
	endgenerate

	assign out_valid = v_s[NST];
	assign out_quo   = quo_s[NST];
	assign out_ovf   = ovf_s[NST];
	assign out_meta  = meta_s[NST];
endmodule
`default_nettype wire

FILE: rtl/core/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix to unit quaternion, fully pipelined.
// Depends on rmq_pkg, rmq_isqrt, rmq_norm_sq and rmq_div.
//
// A matrix word is taken at every rising edge where start is high and busy is
// low; busy stays low, so one matrix can enter every cycle. The word holds the
// nine Q1.30 entries column by column.
// The quaternion word appears on result with result_valid high for exactly one
// cycle, in input order. The path runs through entry, the trace root, three norm
// stages, the norm root, divider setup, the divider and the output register; the
// two square-root pipelines have 32 stages each and the four-lane divider has 32.
// Throughput is one matrix per cycle.
// The receiver cannot stall; results are never held.
// Reset clears all valid bits and loads the threshold registers with their
// defaults. Thresholds are written through wr_en/wr_index/wr_data; write them
// only while no matrix is in flight.
`default_nettype none
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS = 30
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  rmq_pkg::in_t         matrix,
	output logic                 result_valid,
	output rmq_pkg::out_t        result,
	input  wire                  wr_en,
	input  wire [0:0]            wr_index,
	input  wire [31:0]           wr_data
);
	localparam logic signed [34:0] ONE35 = 35'sd1 <<< FRAC_BITS;
	localparam logic signed [33:0] ONE34 = 34'sd1 <<< FRAC_BITS;
	localparam int L = rmq_pkg::LANES;

	logic [30:0]        small_w_q;
	logic signed [31:0] diag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_w_q <= rmq_pkg::SMALL_W_RESET;
			diag_q    <= rmq_pkg::DIAG_RESET;
		end else if (wr_en) begin
			case (wr_index)
				rmq_pkg::CFG_SMALL_W: small_w_q <= wr_data[30:0];
				rmq_pkg::CFG_DIAG:    diag_q    <= wr_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// entry: trace radicand, skew differences, half-turn row pick
	logic               accept;
	logic signed [34:0] trace;
	logic [33:0]        s_clamp;
	rmq_pkg::pre_t      pre_c;
	logic               valid_s1;
	logic [63:0]        rad_s1;
	rmq_pkg::pre_t      pre_s1;

	assign accept = start & ~busy;

	always_comb begin
		trace   = 35'(matrix.col0_x) + 35'(matrix.col1_y) + 35'(matrix.col2_z) + ONE35;
		s_clamp = trace[34] ? '0 : trace[33:0];
		pre_c.d0 = 33'(matrix.col2_y) - 33'(matrix.col1_z);
		pre_c.d1 = 33'(matrix.col0_z) - 33'(matrix.col2_x);
		pre_c.d2 = 33'(matrix.col1_x) - 33'(matrix.col0_y);
		pre_c.bad = 1'b0;
		if (matrix.col0_x > diag_q) begin
			pre_c.v1 = 34'(matrix.col0_x) + ONE34;
			pre_c.v2 = 34'(matrix.col1_x);
			pre_c.v3 = 34'(matrix.col2_x);
		end else if (matrix.col1_y > diag_q) begin
			pre_c.v1 = 34'(matrix.col0_y);
			pre_c.v2 = 34'(matrix.col1_y) + ONE34;
			pre_c.v3 = 34'(matrix.col2_y);
		end else if (matrix.col2_z > diag_q) begin
			pre_c.v1 = 34'(matrix.col0_z);
			pre_c.v2 = 34'(matrix.col1_z);
			pre_c.v3 = 34'(matrix.col2_z) + ONE34;
		end else begin
			pre_c.bad = 1'b1;
			pre_c.v1  = '0;
			pre_c.v2  = '0;
			pre_c.v3  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		rad_s1 <= 64'(s_clamp) << (FRAC_BITS - 2);
		pre_s1 <= pre_c;
	end

	// trace root
	logic                            w_valid;
	logic [31:0]                     w_root;
	logic [$bits(rmq_pkg::pre_t)-1:0] w_pay;

	rmq_isqrt #(.PW($bits(rmq_pkg::pre_t))) u_sqrt_w (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_rad   (rad_s1),
		.in_pay   (pre_s1),
		.out_valid(w_valid),
		.out_root (w_root),
		.out_pay  (w_pay)
	);

	logic           sq_valid;
	logic [63:0]    sq_sum;
	rmq_pkg::norm_t sq_meta;

	rmq_norm_sq u_norm_sq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (w_valid),
		.in_w     (w_root),
		.in_pre   (rmq_pkg::pre_t'(w_pay)),
		.small_w  (small_w_q),
		.out_valid(sq_valid),
		.out_sum  (sq_sum),
		.out_meta (sq_meta)
	);

	// norm root
	logic                              n_valid;
	logic [31:0]                       n_root;
	logic [$bits(rmq_pkg::norm_t)-1:0] n_pay;
	rmq_pkg::norm_t                    nm;

	rmq_isqrt #(.PW($bits(rmq_pkg::norm_t))) u_sqrt_n (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sq_valid),
		.in_rad   (sq_sum),
		.in_pay   (sq_meta),
		.out_valid(n_valid),
		.out_root (n_root),
		.out_pay  (n_pay)
	);

	assign nm = rmq_pkg::norm_t'(n_pay);

	// divider setup: pick numerators and divisor for the taken branch
	logic [L-1:0][63:0]                 num_c;
	logic [31:0]                        den_c;
	rmq_pkg::div_meta_t                 dmeta_c;
	logic                               valid_s5;
	logic [L-1:0][rmq_pkg::NUM_W-1:0]   num_s5;
	logic [31:0]                        den_s5;
	rmq_pkg::div_meta_t                 dmeta_s5;

	always_comb begin
		dmeta_c.half   = nm.half;
		dmeta_c.bad    = nm.bad;
		dmeta_c.zero_n = n_root == '0;
		dmeta_c.w      = nm.w;
		if (nm.half) begin
			den_c = n_root;
			dmeta_c.neg = {nm.vneg, 1'b0};
			for (int i = 0; i < L; i++) begin
				num_c[i] = 64'(nm.ms[i]) << FRAC_BITS;
			end
		end else begin
			den_c = {1'b0, nm.w};
			dmeta_c.neg = {nm.dneg, 1'b0};
			num_c[0] = '0;
			for (int i = 1; i < L; i++) begin
				num_c[i] = 64'(nm.dmag[i-1]) << (FRAC_BITS - 2);
			end
		end
		// add half the divisor for round to nearest
		for (int i = 0; i < L; i++) begin
			num_c[i] = num_c[i] + 64'(den_c >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= n_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < L; i++) begin
			num_s5[i] <= num_c[i][rmq_pkg::NUM_W-1:0];
		end
		den_s5   <= den_c;
		dmeta_s5 <= dmeta_c;
	end

	logic                 q_valid;
	logic [L-1:0][30:0]   q_quo;
	logic [L-1:0]         q_ovf;
	rmq_pkg::div_meta_t   q_meta;

	rmq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s5),
		.in_num   (num_s5),
		.in_den   (den_s5),
		.in_meta  (dmeta_s5),
		.out_valid(q_valid),
		.out_quo  (q_quo),
		.out_ovf  (q_ovf),
		.out_meta (q_meta)
	);

	// sign, saturate, and on the half-turn branch drop everything to zero when the norm is zero
	logic signed [L-1:0][31:0] lane;
	rmq_pkg::out_t             res_c;
	logic                      valid_q;
	rmq_pkg::out_t             result_q;

	always_comb begin
		for (int i = 0; i < L; i++) begin
			if (q_meta.neg[i]) begin
				lane[i] = q_ovf[i] ? 32'h8000_0000 : 32'(-{1'b0, q_quo[i]});
			end else begin
				lane[i] = q_ovf[i] ? 32'h7FFF_FFFF : {1'b0, q_quo[i]};
			end
		end
		if (q_meta.half) begin
			res_c.quat_w = q_meta.zero_n ? '0 : lane[0];
			res_c.quat_x = q_meta.zero_n ? '0 : lane[1];
			res_c.quat_y = q_meta.zero_n ? '0 : lane[2];
			res_c.quat_z = q_meta.zero_n ? '0 : lane[3];
		end else begin
			res_c.quat_w = {1'b0, q_meta.w};
			res_c.quat_x = lane[1];
			res_c.quat_y = lane[2];
			res_c.quat_z = lane[3];
		end
		res_c.near_half_turn = q_meta.half;
		// a missing diagonal only matters on the half-turn branch
		res_c.bad_matrix     = q_meta.half & q_meta.bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_c;
	end

	assign result_valid = valid_q;
	assign result       = result_q;
endmodule
`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for rotation_matrix_to_quaternion.
// Depends on rmq_pkg and the block; predicts each quaternion word in fixed point.
`default_nettype none
module tb;

	localparam int F = 30;
	localparam longint ONE = 64'sd1 << F;
	localparam int LATENCY = 102;
	localparam int RANDOM_ITEMS = 1500;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	rmq_pkg::in_t matrix = '0;
	logic result_valid;
	rmq_pkg::out_t result;
	logic wr_en = 1'b0;
	logic [0:0] wr_index = rmq_pkg::CFG_SMALL_W;
	logic [31:0] wr_data = '0;

	rotation_matrix_to_quaternion DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .matrix(matrix),
		.result_valid(result_valid), .result(result),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor copy of the thresholds
	logic [30:0] small_w_th;
	logic signed [31:0] diag_th;

	rmq_pkg::out_t quat_pending[$];
	int mismatches = 0;
	int words_checked = 0;
	int half_turns = 0;
	int bad_seen = 0;
	longint cycles = 0;
	int idle_pct = 0;

	typedef struct {
		rmq_pkg::in_t m;
		logic check_fixed;
		rmq_pkg::out_t fixed_q;
	} stim_row_t;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint sat_word(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned abs64(longint v);
		return v < 0 ? 64'd0 - longint'(unsigned'(v)) : longint'(unsigned'(v));
	endfunction

	function automatic longint div_nearest(logic neg, longint unsigned mag,
			longint unsigned den);
		longint unsigned q;
		q = (mag + den / 2) / den;
		if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic rmq_pkg::out_t quaternion_of(rmq_pkg::in_t mt);
		longint m[9];
		longint q[4];
		longint d[3];
		longint s;
		longint unsigned w, sum, n;
		longint unsigned mg[4];
		logic big;
		rmq_pkg::out_t r;
		m[0] = mt.col0_x; m[1] = mt.col0_y; m[2] = mt.col0_z;
		m[3] = mt.col1_x; m[4] = mt.col1_y; m[5] = mt.col1_z;
		m[6] = mt.col2_x; m[7] = mt.col2_y; m[8] = mt.col2_z;
		r = '0;
		s = m[0] + m[4] + m[8] + ONE;
		if (s < 0) s = 0;
		w = int_sqrt(longint'(unsigned'(s)) << (F - 2));
		q[0] = sat_word(longint'(w));
		if (w <= longint'(small_w_th)) begin
			r.near_half_turn = 1'b1;
			if (m[0] > diag_th) begin
				q[1] = ONE + m[0]; q[2] = m[3]; q[3] = m[6];
			end else if (m[4] > diag_th) begin
				q[1] = m[1]; q[2] = ONE + m[4]; q[3] = m[7];
			end else if (m[8] > diag_th) begin
				q[1] = m[2]; q[2] = m[5]; q[3] = ONE + m[8];
			end else begin
				r.bad_matrix = 1'b1;
				q[1] = 0; q[2] = 0; q[3] = 0;
			end
			big = 1'b0;
			sum = 0;
			for (int i = 0; i < 4; i++) begin
				mg[i] = abs64(q[i]);
				if (mg[i] >= (64'd1 << 31)) big = 1'b1;
			end
			for (int i = 0; i < 4; i++) begin
				if (big) mg[i] >>= 1;
				sum += mg[i] * mg[i];
			end
			n = int_sqrt(sum);
			if (n != 0)
				for (int i = 0; i < 4; i++)
					q[i] = sat_word(div_nearest(q[i] < 0, mg[i] << F, n));
		end else begin
			d[0] = m[7] - m[5];
			d[1] = m[2] - m[6];
			d[2] = m[3] - m[1];
			for (int i = 0; i < 3; i++)
				q[i + 1] = sat_word(div_nearest(d[i] < 0, abs64(d[i]) << (F - 2), w));
		end
		r.quat_w = q[0][31:0];
		r.quat_x = q[1][31:0];
		r.quat_y = q[2][31:0];
		r.quat_z = q[3][31:0];
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("rotation_matrix_to_quaternion: mismatch");
			$finish;
		end
	end

	// compare each result word against the oldest prediction
	always @(posedge clk) begin
		rmq_pkg::out_t exp_q;
		if (arst_n && result_valid) begin
			if (quat_pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word %h", result);
			end else begin
				exp_q = quat_pending.pop_front();
				words_checked++;
				if (exp_q.near_half_turn) half_turns++;
				if (exp_q.bad_matrix) bad_seen++;
				if (result !== exp_q) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word %0d: expected w=%h x=%h y=%h z=%h h=%b b=%b, got w=%h x=%h y=%h z=%h h=%b b=%b",
							words_checked, exp_q.quat_w, exp_q.quat_x, exp_q.quat_y,
							exp_q.quat_z, exp_q.near_half_turn, exp_q.bad_matrix,
							result.quat_w, result.quat_x, result.quat_y, result.quat_z,
							result.near_half_turn, result.bad_matrix);
				end
			end
		end
	end

	task automatic write_reg(logic [0:0] idx, logic [31:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == rmq_pkg::CFG_SMALL_W) small_w_th = val[30:0];
		else diag_th = val;
		@(posedge clk);
	endtask

	task automatic drain();
		while (quat_pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	// present one matrix word; start stays high across back-to-back words
	task automatic send_matrix(rmq_pkg::in_t mt, logic more);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		matrix <= mt;
		@(posedge clk);
		while (busy) @(posedge clk);
		quat_pending.push_back(quaternion_of(mt));
		if (!more) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] rand_entry();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'sh8000_0000 + $urandom_range(3);
			2: return 32'sh7FFF_FFFF - $urandom_range(3);
			default: return $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
		endcase
	endfunction

	// mostly near-rotations with random content, some near half turns
	function automatic rmq_pkg::in_t rand_matrix();
		rmq_pkg::in_t mt;
		int kind;
		kind = $urandom_range(9);
		mt = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
			rand_entry(), rand_entry(), rand_entry(), rand_entry()};
		if (kind < 3) begin
			// trace near -1: pick diagonal so one qualifies or none does
			mt.col0_x = -32'sh4000_0000 + $signed($urandom_range(40000000));
			mt.col1_y = -32'sh4000_0000 + $signed($urandom_range(40000000));
			mt.col2_z = -32'sh4000_0000 + $signed($urandom_range(40000000))
				- (mt.col0_x + 32'sh4000_0000) - (mt.col1_y + 32'sh4000_0000)
				+ 32'sh4000_0000 - 32'sh4000_0000 * 0;
			mt.col2_z = -32'sh4000_0000 - mt.col0_x - mt.col1_y
				- $signed($urandom_range(2000));
		end else if (kind < 8) begin
			mt.col0_x = $signed($urandom_range(32'h4000_0000)) - 32'sh2000_0000;
			mt.col1_y = $signed($urandom_range(32'h4000_0000)) - 32'sh2000_0000;
			mt.col2_z = $signed($urandom_range(32'h4000_0000)) - 32'sh2000_0000;
		end
		return mt;
	endfunction

	stim_row_t rows[$];

	initial begin
		stim_row_t row;
		rmq_pkg::in_t mt;
		int n;
		small_w_th = rmq_pkg::SMALL_W_RESET;
		diag_th = rmq_pkg::DIAG_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		row.check_fixed = 1'b1;
		row.m = '0;
		row.m.col0_x = 32'sh4000_0000; row.m.col1_y = 32'sh4000_0000;
		row.m.col2_z = 32'sh4000_0000;
		row.fixed_q = '0; row.fixed_q.quat_w = 32'sh4000_0000;
		rows.push_back(row);
		// trace -3: radicand clamps, no diagonal qualifies
		row.m = '0;
		row.m.col0_x = -32'sh4000_0000; row.m.col1_y = -32'sh4000_0000;
		row.m.col2_z = -32'sh4000_0000;
		row.fixed_q = '0; row.fixed_q.near_half_turn = 1'b1;
		row.fixed_q.bad_matrix = 1'b1;
		rows.push_back(row);
		row.check_fixed = 1'b0;
		// half turns about each axis
		for (int a = 0; a < 3; a++) begin
			row.m = '0;
			row.m.col0_x = a == 0 ? 32'sh4000_0000 : -32'sh4000_0000;
			row.m.col1_y = a == 1 ? 32'sh4000_0000 : -32'sh4000_0000;
			row.m.col2_z = a == 2 ? 32'sh4000_0000 : -32'sh4000_0000;
			rows.push_back(row);
		end
		row.m = {9{32'sh8000_0000}}; rows.push_back(row);
		row.m = {9{32'sh7FFF_FFFF}}; rows.push_back(row);
		row.m = {32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF};
		rows.push_back(row);
		row.m = ~row.m; rows.push_back(row);
		row.m = '0; rows.push_back(row);
		// 90 degrees about z
		row.m = '0; row.m.col0_y = 32'sh4000_0000; row.m.col1_x = -32'sh4000_0000;
		row.m.col2_z = 32'sh4000_0000; rows.push_back(row);
		for (int k = 0; k < 6; k++) begin
			row.m = rand_matrix(); rows.push_back(row);
		end
		foreach (rows[i]) begin
			send_matrix(rows[i].m, i + 1 < rows.size());
			if (rows[i].check_fixed && quaternion_of(rows[i].m) !== rows[i].fixed_q) begin
				mismatches++;
				$display("directed row %0d: predictor disagrees with typed value", i);
			end
		end
		drain();

		// random phases across threshold settings, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(rmq_pkg::CFG_SMALL_W, 32'd0);
					write_reg(rmq_pkg::CFG_DIAG, 32'hC000_0000);
				end
				1: begin
					write_reg(rmq_pkg::CFG_SMALL_W, 32'h4000_0000);
					write_reg(rmq_pkg::CFG_DIAG, 32'h4000_0000);
				end
				2: begin
					write_reg(rmq_pkg::CFG_SMALL_W, 32'h7FFF_FFFF);
					write_reg(rmq_pkg::CFG_DIAG, 32'h0);
				end
				3: begin
					write_reg(rmq_pkg::CFG_SMALL_W, $urandom);
					write_reg(rmq_pkg::CFG_DIAG, $urandom);
				end
				4: begin
					write_reg(rmq_pkg::CFG_SMALL_W, 32'd20000000);
					write_reg(rmq_pkg::CFG_DIAG, 32'hC100_0000);
				end
				default: begin
					write_reg(rmq_pkg::CFG_SMALL_W, 32'(rmq_pkg::SMALL_W_RESET));
					write_reg(rmq_pkg::CFG_DIAG, rmq_pkg::DIAG_RESET);
				end
			endcase
			idle_pct = ph < 2 ? 21 : (ph < 4 ? 58 : 0);
			n = RANDOM_ITEMS / 6;
			for (int i = 0; i < n; i++) begin
				mt = rand_matrix();
				send_matrix(mt, i + 1 < n && $urandom_range(3) != 0);
			end
			drain();
		end

		$display("checked %0d quaternion words, %0d near half turn, %0d bad matrix",
			words_checked, half_turns, bad_seen);
		if (mismatches == 0 && quat_pending.size() == 0) begin
			$display("rotation_matrix_to_quaternion: match");
		end else begin
			$display("%0d mismatches, %0d words outstanding", mismatches, quat_pending.size());
			$display("rotation_matrix_to_quaternion: mismatch");
		end
		$finish;
	end
endmodule
`default_nettype wire
